[sv/lets_pkg.sv]
// ----------------------------------------------------------------------------
// lets_pkg
// Shared types and defaults for the local expansion Taylor shift block.
// ----------------------------------------------------------------------------
package lets_pkg;

  localparam int DEF_MAX_TERMS = 16;
  localparam int DEF_FRAC_BITS = 16;
  localparam int CFG_W         = 5;
  localparam logic [CFG_W-1:0] TERMS_RESET = 5'd16;

  typedef enum logic [3:0] {
    S_LOAD,
    S_P_RD,
    S_P_CUR,
    S_MUL,
    S_UPD,
    S_ACC_RD,
    S_ACC_WR,
    S_EM_RD,
    S_EM_LD,
    S_EM_OUT
  } lets_state_t;

  typedef struct packed {
    logic load_we;
    logic cap_z;
    logic cur_ld;
    logic mul_en;
    logic upd_en;
    logic acc_en;
    logic out_ld;
    logic out_last;
    logic clr_flag;
  } lets_cmd_t;

endpackage

[sv/lets_ram.sv]
// ----------------------------------------------------------------------------
// lets_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lets_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lets_dp.sv]
// ----------------------------------------------------------------------------
// lets_dp
// Datapath: coefficient and accumulator RAMs, complex multiplier, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module lets_dp #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lets_pkg::lets_cmd_t          cmd,
  input  logic [$clog2(MAX_TERMS)-1:0] waddr,
  input  logic [$clog2(MAX_TERMS)-1:0] raddr,
  input  logic signed [31:0]           src_re,
  input  logic signed [31:0]           src_im,
  input  logic signed [31:0]           acc_re,
  input  logic signed [31:0]           acc_im,
  input  logic signed [31:0]           shift_re,
  input  logic signed [31:0]           shift_im,
  output logic signed [31:0]           out_re,
  output logic signed [31:0]           out_im,
  output logic [3:0]                   coef_index,
  output logic                         last_out,
  output logic                         saturated
);
  import lets_pkg::*;

  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  function automatic logic ovf32(input logic signed [65:0] x);
    ovf32 = (x > 66'sd2147483647) || (x < -66'sd2147483648);
  endfunction

  logic [63:0] coef_wdata, coef_rdata, accb_rdata;
  logic        coef_we;

  logic signed [31:0] z_re, z_im, cur_re, cur_im, nxt_re, nxt_im;
  logic signed [63:0] pa, pb, pc, pd;
  logic               flag;

  logic signed [31:0] rd_re, rd_im, ab_re, ab_im;
  logic signed [64:0] prod_re, prod_im, rnd_re, rnd_im;
  logic signed [65:0] dif_re, dif_im, sum_re, sum_im;
  logic signed [31:0] upd_re, upd_im, acs_re, acs_im;
  logic               upd_ovf, acc_ovf;

  assign rd_re = coef_rdata[31:0];
  assign rd_im = coef_rdata[63:32];
  assign ab_re = accb_rdata[31:0];
  assign ab_im = accb_rdata[63:32];

  always_comb begin
    prod_re = 65'(pa) - 65'(pb);
    prod_im = 65'(pc) + 65'(pd);
    rnd_re  = (prod_re + HALF) >>> FRAC_BITS;
    rnd_im  = (prod_im + HALF) >>> FRAC_BITS;
    dif_re  = 66'(cur_re) - 66'(rnd_re);
    dif_im  = 66'(cur_im) - 66'(rnd_im);
    upd_re  = sat32(dif_re);
    upd_im  = sat32(dif_im);
    upd_ovf = ovf32(dif_re) | ovf32(dif_im);
    sum_re  = 66'(rd_re) + 66'(ab_re);
    sum_im  = 66'(rd_im) + 66'(ab_im);
    acs_re  = sat32(sum_re);
    acs_im  = sat32(sum_im);
    acc_ovf = ovf32(sum_re) | ovf32(sum_im);
  end

  always_comb begin
    coef_we = cmd.load_we | cmd.upd_en | cmd.acc_en;
    if (cmd.load_we) begin
      coef_wdata = {src_im, src_re};
    end else if (cmd.upd_en) begin
      coef_wdata = {upd_im, upd_re};
    end else begin
      coef_wdata = {acs_im, acs_re};
    end
  end

  lets_ram #(.WIDTH(64), .DEPTH(MAX_TERMS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (waddr),
    .wdata (coef_wdata),
    .raddr (raddr),
    .rdata (coef_rdata)
  );

  lets_ram #(.WIDTH(64), .DEPTH(MAX_TERMS)) u_accb_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (waddr),
    .wdata ({acc_im, acc_re}),
    .raddr (raddr),
    .rdata (accb_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_z) begin
      z_re <= shift_re;
      z_im <= shift_im;
    end
    if (cmd.cur_ld) begin
      cur_re <= rd_re;
      cur_im <= rd_im;
    end
    if (cmd.mul_en) begin
      pa     <= z_re * rd_re;
      pb     <= z_im * rd_im;
      pc     <= z_re * rd_im;
      pd     <= z_im * rd_re;
      nxt_re <= rd_re;
      nxt_im <= rd_im;
    end
    // The coefficient just read becomes the one updated by the next step.
    if (cmd.upd_en) begin
      cur_re <= nxt_re;
      cur_im <= nxt_im;
    end
    if (cmd.out_ld) begin
      out_re     <= rd_re;
      out_im     <= rd_im;
      coef_index <= 4'(raddr);
      last_out   <= cmd.out_last;
      saturated  <= flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (cmd.clr_flag) begin
      flag <= 1'b0;
    end else if ((cmd.upd_en && upd_ovf) || (cmd.acc_en && acc_ovf)) begin
      flag <= 1'b1;
    end
  end

endmodule

[sv/lets_ctrl.sv]
// ----------------------------------------------------------------------------
// lets_ctrl
// Controller: load counting, Horner pass and step sequencing, accumulate and
// emit sweeps, and the length register.
// ----------------------------------------------------------------------------
module lets_ctrl #(
  parameter int MAX_TERMS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lets_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lets_pkg::lets_cmd_t          cmd,
  output logic [$clog2(MAX_TERMS)-1:0] waddr,
  output logic [$clog2(MAX_TERMS)-1:0] raddr
);
  import lets_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  lets_state_t state, state_next;
  logic [CFG_W-1:0] terms;
  logic [CW-1:0]    load_count, load_count_next;
  logic [AW-1:0]    k, k_next;
  logic [CW-1:0]    l, l_next;
  logic [CW-1:0]    p;
  logic [AW-1:0]    lc_idx;
  logic             in_acc, complete;
  logic [CW:0]      k2;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    if (terms == '0) begin
      p = CW'(1);
    end else if (32'(terms) > MAX_TERMS) begin
      p = CW'(MAX_TERMS);
    end else begin
      p = CW'(terms);
    end
    lc_idx   = (32'(load_count) >= MAX_TERMS) ? '0 : load_count[AW-1:0];
    complete = ((CW + 1)'(lc_idx) + 1'b1) >= (CW + 1)'(p);
    k2       = (CW + 1)'(k) + (CW + 1)'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      terms      <= TERMS_RESET;
      load_count <= '0;
      k          <= '0;
      l          <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      k          <= k_next;
      l          <= l_next;
      if (cfg_valid && cfg_ready) begin
        terms <= cfg_data;
      end
    end
  end

  // Next state and counters.
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    k_next          = k;
    l_next          = l;
    case (state)
      S_LOAD: begin
        if (in_acc) begin
          load_count_next = complete ? '0 : CW'(lc_idx) + 1'b1;
          if (complete) begin
            if (p == CW'(1)) begin
              k_next     = '0;
              state_next = S_ACC_RD;
            end else begin
              l_next     = CW'(1);
              k_next     = AW'(p - CW'(2));
              state_next = S_P_RD;
            end
          end
        end
      end
      S_P_RD:  state_next = S_P_CUR;
      S_P_CUR: state_next = S_MUL;
      S_MUL:   state_next = S_UPD;
      S_UPD: begin
        if (k2 < (CW + 1)'(p)) begin
          k_next     = k + 1'b1;
          state_next = S_MUL;
        end else if (l + 1'b1 == p) begin
          k_next     = '0;
          state_next = S_ACC_RD;
        end else begin
          // Next pass starts one coefficient lower.
          l_next     = l + 1'b1;
          k_next     = AW'(p - CW'(2) - l);
          state_next = S_P_RD;
        end
      end
      S_ACC_RD: state_next = S_ACC_WR;
      S_ACC_WR: begin
        if (CW'(k) + 1'b1 == p) begin
          k_next     = '0;
          state_next = S_EM_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_ACC_RD;
        end
      end
      S_EM_RD: state_next = S_EM_LD;
      S_EM_LD: state_next = S_EM_OUT;
      S_EM_OUT: begin
        if (out_ready) begin
          if (CW'(k) + 1'b1 == p) begin
            k_next     = '0;
            state_next = S_LOAD;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_EM_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    waddr     = k;
    raddr     = k;
    case (state)
      S_LOAD: begin
        in_ready    = 1'b1;
        waddr       = lc_idx;
        cmd.load_we = in_acc;
        cmd.cap_z   = in_acc && complete;
      end
      S_P_RD: ;
      S_P_CUR: begin
        cmd.cur_ld = 1'b1;
        raddr      = k + 1'b1;
      end
      S_MUL:    cmd.mul_en = 1'b1;
      S_UPD: begin
        cmd.upd_en = 1'b1;
        raddr      = AW'(k2);
      end
      S_ACC_RD: ;
      S_ACC_WR: cmd.acc_en = 1'b1;
      S_EM_RD:  ;
      S_EM_LD: begin
        cmd.out_ld   = 1'b1;
        cmd.out_last = (CW'(k) + 1'b1 == p);
      end
      S_EM_OUT: begin
        out_valid    = 1'b1;
        cmd.clr_flag = out_ready && (CW'(k) + 1'b1 == p);
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_start_work: assert property (@(posedge clk) disable iff (rst)
    (in_acc && complete) |=> (state != S_LOAD))
    else $error("completed set did not start processing");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (CW'(k) < p))
    else $error("coefficient index beyond set length");

  a_pass_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (l < p) && (k2 <= (CW + 1)'(p)))
    else $error("Horner step outside its pass");

endmodule

[sv/local_expansion_taylor_shift.sv]
// ----------------------------------------------------------------------------
// local_expansion_taylor_shift
// Local-to-local expansion translation by Horner Taylor shift, Q16.16.
// ----------------------------------------------------------------------------
// Usage: send p = terms_in_use coefficient requests on the input channel
// (in_valid/in_ready), each with a parent coefficient and the child's
// accumulator coefficient; the shift vector is taken from the request that
// completes the set. The block then shifts the set with one shared complex
// multiplier and returns p results on the output channel (out_valid/
// out_ready) in index order, last_out marking the final one and saturated
// set on all of them if any step of the set clipped.
// Sequence: in_ready stays high while loading, so requests are taken back to
// back. Then come the Horner passes (each opened by a read and a load of the
// current coefficient, then a multiply and an update state per Horner step)
// and the accumulate sweep (a read and a write per coefficient); each result
// then passes through the RAM read port and the output register. The input
// is not ready from the completing request until the last result is taken.
// A stalled receiver simply holds the current result. Reset clears the
// controller, sets the length to 16 and drops any partial set; the buffer
// RAMs are not cleared. Write cfg_data only while the block is idle.
// ----------------------------------------------------------------------------
module local_expansion_taylor_shift #(
  parameter int MAX_TERMS = lets_pkg::DEF_MAX_TERMS,
  parameter int FRAC_BITS = lets_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lets_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         src_re,
  input  logic signed [31:0]         src_im,
  input  logic signed [31:0]         acc_re,
  input  logic signed [31:0]         acc_im,
  input  logic signed [31:0]         shift_re,
  input  logic signed [31:0]         shift_im,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_re,
  output logic signed [31:0]         out_im,
  output logic [3:0]                 coef_index,
  output logic                       last_out,
  output logic                       saturated
);
  import lets_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);

  lets_cmd_t     cmd;
  logic [AW-1:0] waddr, raddr;

  lets_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr     (raddr)
  );

  lets_dp #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .waddr      (waddr),
    .raddr      (raddr),
    .src_re     (src_re),
    .src_im     (src_im),
    .acc_re     (acc_re),
    .acc_im     (acc_im),
    .shift_re   (shift_re),
    .shift_im   (shift_im),
    .out_re     (out_re),
    .out_im     (out_im),
    .coef_index (coef_index),
    .last_out   (last_out),
    .saturated  (saturated)
  );

endmodule
